// ===== design/fla_pkg.sv =====
// Shared types, constants and helpers for the free-list block allocator.
package fla_pkg;

	localparam int MAX_BLOCKS = 256;
	localparam int IDX_W      = $clog2(MAX_BLOCKS);
	localparam int CNT_W      = $clog2(MAX_BLOCKS + 1);
	localparam int CFG_W      = 9;
	localparam int CMD_W      = 2;
	localparam int STAT_W     = 2;
	localparam int APB_DW     = 32;
	localparam int APB_AW     = 3;

	// Register index of block_count on the configuration port.
	localparam logic REG_BLOCK_COUNT = 1'b0;

	typedef enum logic [CMD_W-1:0] {
		CMD_ALLOC   = 2'd0,
		CMD_FREE    = 2'd1,
		CMD_REBUILD = 2'd2
	} cmd_t;

	typedef enum logic [STAT_W-1:0] {
		STAT_OK    = 2'd0,
		STAT_EMPTY = 2'd1,
		STAT_RANGE = 2'd2
	} stat_t;

	typedef enum logic [1:0] {
		S_IDLE,
		S_EXEC,
		S_SWEEP
	} fsm_t;

	// Controller to datapath.
	typedef struct packed {
		logic idle;
		logic capture;
		logic exec;
		logic sweep_step;
		logic sweep_commit;
	} ctrl_cmd_t;

	// Datapath to controller.
	typedef struct packed {
		logic needs_sweep;
		logic at_idx;
		logic out_room;
	} dp_stat_t;

	// Clamp the programmed block count into 1 .. MAX_BLOCKS.
	function automatic logic [CNT_W-1:0] active_count(input logic [CFG_W-1:0] v);
		logic [CNT_W-1:0] n;
		begin
			if (v == '0) begin
				n = CNT_W'(1);
			end else if (32'(v) > MAX_BLOCKS) begin
				n = CNT_W'(MAX_BLOCKS);
			end else begin
				n = CNT_W'(v);
			end
			return n;
		end
	endfunction

endpackage

// ===== design/free_list_block_allocator.sv =====
// Top level of the free-list block allocator: configuration port, controller, datapath.
//
// Hands out block indices from a pool of block_count equal-size blocks kept on a
// last-in first-out free list. Each input transaction carries a command (allocate,
// free a block, rebuild the list) and a block index; each one yields exactly one
// result transaction with a status, the granted index and the free count.
// Both channels use valid/stall; a transaction moves at an edge with valid high
// and stall low. in_stall is high while a command is in flight, so one command
// is worked on at a time.
// Sequence: the accepting edge reads the link RAM (one read port, registered); the
// next edge that finds room in the result register updates the list and loads the
// result, and in_stall drops with it. A free of a block the list has not yet reached
// since the last rebuild first sweeps the links from the frontier up to that block,
// one RAM write a cycle.
// The result register parts the channels: a new command is accepted while a
// result still waits; a stalled receiver holds the next update until the slot
// frees.
// Reset (arst_n low) sets block_count to 256 and leaves a full pool of blocks
// 0..255 chained in ascending order; no RAM clearing is needed, links at or above
// the frontier are implied. block_count is written over APB at address 0 and
// takes effect on the next rebuild.
module free_list_block_allocator (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              psel,
	input  logic                              penable,
	input  logic                              pwrite,
	input  logic [fla_pkg::APB_AW-1:0]        paddr,
	input  logic [fla_pkg::APB_DW-1:0]        pwdata,
	output logic [fla_pkg::APB_DW-1:0]        prdata,
	output logic                              pready,
	input  logic                              in_valid,
	output logic                              in_stall,
	input  logic [fla_pkg::CMD_W-1:0]         command,
	input  logic [fla_pkg::IDX_W-1:0]         block_index,
	output logic                              out_valid,
	input  logic                              out_stall,
	output logic [fla_pkg::STAT_W-1:0]        status,
	output logic [fla_pkg::IDX_W-1:0]         granted_index,
	output logic [fla_pkg::CNT_W-1:0]         free_count
);

	fla_pkg::ctrl_cmd_t          ctl;
	fla_pkg::dp_stat_t           stat;
	logic                        reg_sel;
	logic                        cfg_we;
	logic [fla_pkg::CFG_W-1:0]   cfg_rdata;

	// Decode the word index; only block_count exists.
	assign reg_sel = (paddr[2] == fla_pkg::REG_BLOCK_COUNT);
	assign pready  = 1'b1;
	assign cfg_we  = psel && penable && pwrite && pready && reg_sel;
	assign prdata  = reg_sel ? fla_pkg::APB_DW'(cfg_rdata) : '0;

	// Hold the input side while a command is in flight.
	assign in_stall = !ctl.idle;

	fla_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.stat     (stat),
		.ctl      (ctl)
	);

	fla_dp u_dp (
		.clk           (clk),
		.arst_n        (arst_n),
		.command       (command),
		.block_index   (block_index),
		.cfg_we        (cfg_we),
		.cfg_wdata     (pwdata[fla_pkg::CFG_W-1:0]),
		.cfg_rdata     (cfg_rdata),
		.ctl           (ctl),
		.stat          (stat),
		.out_stall     (out_stall),
		.out_valid     (out_valid),
		.status        (status),
		.granted_index (granted_index),
		.free_count    (free_count)
	);

	// An accepted transaction closes the input until its result is produced.
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall |=> in_stall)
		else $error("input accepted again directly after a transaction");

	// A failed request grants nothing.
	a_no_grant_on_error: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && status != fla_pkg::STAT_OK |-> granted_index == '0)
		else $error("nonzero grant with an error status");

	// The free count never exceeds the pool size.
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> 32'(free_count) <= fla_pkg::MAX_BLOCKS)
		else $error("free count above pool size");

	// Sweeping never runs while the controller is idle.
	a_sweep_not_idle: assert property (@(posedge clk) disable iff (!arst_n)
		ctl.sweep_step |-> !ctl.idle && in_stall)
		else $error("link sweep while idle");

endmodule

// ===== design/fla_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
module fla_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 256
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem_q[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

// ===== design/fla_ctrl.sv =====
// Controller state machine of the free-list block allocator.
module fla_ctrl (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	input  fla_pkg::dp_stat_t    stat,
	output fla_pkg::ctrl_cmd_t   ctl
);

	fla_pkg::fsm_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= fla_pkg::S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			fla_pkg::S_IDLE: begin
				if (in_valid) begin
					state_d = fla_pkg::S_EXEC;
				end
			end
			fla_pkg::S_EXEC: begin
				if (stat.needs_sweep) begin
					state_d = fla_pkg::S_SWEEP;
				end else if (stat.out_room) begin
					state_d = fla_pkg::S_IDLE;
				end
			end
			fla_pkg::S_SWEEP: begin
				if (stat.at_idx && stat.out_room) begin
					state_d = fla_pkg::S_IDLE;
				end
			end
			default: state_d = fla_pkg::S_IDLE;
		endcase
	end

	always_comb begin
		ctl = '0;
		unique case (state_q)
			fla_pkg::S_IDLE: begin
				ctl.idle    = 1'b1;
				ctl.capture = in_valid;
			end
			fla_pkg::S_EXEC: begin
				ctl.exec = !stat.needs_sweep && stat.out_room;
			end
			fla_pkg::S_SWEEP: begin
				ctl.sweep_step   = !stat.at_idx;
				ctl.sweep_commit = stat.at_idx && stat.out_room;
			end
			default: ctl = '0;
		endcase
	end

endmodule

// ===== design/fla_dp.sv =====
// Datapath of the free-list block allocator: list state, link RAM, result register.
module fla_dp (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic [fla_pkg::CMD_W-1:0]    command,
	input  logic [fla_pkg::IDX_W-1:0]    block_index,
	input  logic                         cfg_we,
	input  logic [fla_pkg::CFG_W-1:0]    cfg_wdata,
	output logic [fla_pkg::CFG_W-1:0]    cfg_rdata,
	input  fla_pkg::ctrl_cmd_t           ctl,
	output fla_pkg::dp_stat_t            stat,
	input  logic                         out_stall,
	output logic                         out_valid,
	output logic [fla_pkg::STAT_W-1:0]   status,
	output logic [fla_pkg::IDX_W-1:0]    granted_index,
	output logic [fla_pkg::CNT_W-1:0]    free_count
);

	localparam int IW = fla_pkg::IDX_W;
	localparam int CW = fla_pkg::CNT_W;

	logic [fla_pkg::CFG_W-1:0]  bcount_q;
	logic [fla_pkg::CMD_W-1:0]  cmd_q;
	logic [IW-1:0]              idx_q;
	logic [IW-1:0]              head_q;
	logic                       empty_q;
	logic [CW-1:0]              free_q;
	logic [CW-1:0]              mark_q;
	// Entries at or above the frontier still hold their rebuild link implicitly.
	logic [CW-1:0]              front_q;

	logic                       out_valid_q;
	logic [fla_pkg::STAT_W-1:0] status_q;
	logic [IW-1:0]              granted_q;
	logic [CW-1:0]              free_count_q;

	logic [IW-1:0] rd_link;
	logic [IW-1:0] link_imp;
	logic [IW-1:0] link;
	logic [CW-1:0] idx_ext;
	logic [CW-1:0] head_ext;
	logic          in_range;
	logic          do_op;
	logic          commit;
	logic          ram_we;
	logic [IW-1:0] ram_waddr;
	logic [IW-1:0] ram_wdata;

	logic [fla_pkg::STAT_W-1:0] res_status;
	logic [IW-1:0]              res_granted;
	logic [IW-1:0]              head_d;
	logic                       empty_d;
	logic [CW-1:0]              free_d;
	logic [CW-1:0]              mark_d;
	logic [CW-1:0]              front_d;
	logic [CW-1:0]              n_active;

	assign idx_ext  = {1'b0, idx_q};
	assign head_ext = {1'b0, head_q};
	assign in_range = idx_ext < mark_q;
	assign n_active = fla_pkg::active_count(bcount_q);

	// Rebuild link: next block up, or block zero at the end of the chain.
	assign link_imp = ((head_ext + CW'(1)) == mark_q) ? '0 : IW'(head_ext + CW'(1));
	assign link     = (head_ext >= front_q) ? link_imp : rd_link;

	assign stat.needs_sweep = (cmd_q == fla_pkg::CMD_FREE) && in_range && (idx_ext >= front_q);
	assign stat.at_idx      = (front_q == idx_ext);
	assign stat.out_room    = !out_valid_q || !out_stall;

	assign do_op  = ctl.exec || ctl.sweep_commit;
	assign commit = ctl.sweep_commit || (ctl.exec && (cmd_q == fla_pkg::CMD_FREE) && in_range);

	// Sweep materializes implicit links below the freed block before it is overwritten.
	assign ram_we    = ctl.sweep_step || commit;
	assign ram_waddr = ctl.sweep_step ? front_q[IW-1:0] : idx_q;
	assign ram_wdata = ctl.sweep_step ? IW'(front_q + CW'(1)) : head_q;

	fla_ram #(
		.WIDTH (IW),
		.DEPTH (fla_pkg::MAX_BLOCKS)
	) u_links (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.re    (ctl.capture),
		.raddr (head_q),
		.rdata (rd_link)
	);

	always_comb begin
		res_status  = fla_pkg::STAT_OK;
		res_granted = '0;
		head_d      = head_q;
		empty_d     = empty_q;
		free_d      = free_q;
		mark_d      = mark_q;
		front_d     = front_q;
		case (cmd_q)
			fla_pkg::CMD_ALLOC: begin
				if (empty_q || free_q == '0) begin
					res_status = fla_pkg::STAT_EMPTY;
				end else begin
					res_granted = head_q;
					head_d      = link;
					free_d      = free_q - CW'(1);
					empty_d     = (free_q == CW'(1));
				end
			end
			fla_pkg::CMD_FREE: begin
				if (!in_range) begin
					res_status = fla_pkg::STAT_RANGE;
				end else begin
					head_d  = idx_q;
					empty_d = 1'b0;
					if (free_q < mark_q) begin
						free_d = free_q + CW'(1);
					end
					if (idx_ext >= front_q) begin
						front_d = idx_ext + CW'(1);
					end
				end
			end
			fla_pkg::CMD_REBUILD: begin
				head_d  = '0;
				empty_d = 1'b0;
				free_d  = n_active;
				mark_d  = n_active;
				front_d = '0;
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bcount_q    <= fla_pkg::CFG_W'(fla_pkg::MAX_BLOCKS);
			head_q      <= '0;
			empty_q     <= 1'b0;
			free_q      <= CW'(fla_pkg::MAX_BLOCKS);
			mark_q      <= CW'(fla_pkg::MAX_BLOCKS);
			front_q     <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_we) begin
				bcount_q <= cfg_wdata;
			end
			if (ctl.sweep_step) begin
				front_q <= front_q + CW'(1);
			end
			if (do_op) begin
				head_q  <= head_d;
				empty_q <= empty_d;
				free_q  <= free_d;
				mark_q  <= mark_d;
				front_q <= front_d;
			end
			if (do_op) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.capture) begin
			cmd_q <= command;
			idx_q <= block_index;
		end
		if (do_op) begin
			status_q     <= res_status;
			granted_q    <= res_granted;
			free_count_q <= free_d;
		end
	end

	assign cfg_rdata     = bcount_q;
	assign out_valid     = out_valid_q;
	assign status        = status_q;
	assign granted_index = granted_q;
	assign free_count    = free_count_q;

endmodule

// ===== tb/sv/free_list_block_allocator_tb.sv =====
`timescale 1ns / 1ps
// Self-checking testbench for the free-list block allocator: directed table, then random phases.
module free_list_block_allocator_tb;

	// Command code with no meaning; the block must answer it and change nothing.
	localparam logic [fla_pkg::CMD_W-1:0] CMD_NOP = 2'd3;
	// Sweeping frees are the slowest commands; this limit covers the worst run several times over.
	localparam int unsigned CYCLE_LIMIT = 1_500_000;
	localparam int unsigned ITEMS_PER_PHASE = 100;
	localparam int unsigned PHASES = 8;

	typedef struct packed {
		logic [fla_pkg::STAT_W-1:0] status;
		logic [fla_pkg::IDX_W-1:0]  granted;
		logic [fla_pkg::CNT_W-1:0]  count;
	} pool_reply_t;

	typedef struct {
		bit                        is_cfg;
		logic [fla_pkg::CFG_W-1:0] cfg;
		logic [fla_pkg::CMD_W-1:0] cmd;
		logic [fla_pkg::IDX_W-1:0] idx;
		bit                        typed;
		pool_reply_t               reply;
	} plan_row_t;

	logic                         clk = 1'b0;
	logic                         arst_n;
	logic                         psel, penable, pwrite;
	logic [fla_pkg::APB_AW-1:0]   paddr;
	logic [fla_pkg::APB_DW-1:0]   pwdata;
	logic [fla_pkg::APB_DW-1:0]   prdata;
	logic                         pready;
	logic                         in_valid, in_stall;
	logic [fla_pkg::CMD_W-1:0]    command;
	logic [fla_pkg::IDX_W-1:0]    block_index;
	logic                         out_valid, out_stall;
	logic [fla_pkg::STAT_W-1:0]   status;
	logic [fla_pkg::IDX_W-1:0]    granted_index;
	logic [fla_pkg::CNT_W-1:0]    free_count;

	free_list_block_allocator dut (
		.clk(clk), .arst_n(arst_n),
		.psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
		.pwdata(pwdata), .prdata(prdata), .pready(pready),
		.in_valid(in_valid), .in_stall(in_stall),
		.command(command), .block_index(block_index),
		.out_valid(out_valid), .out_stall(out_stall),
		.status(status), .granted_index(granted_index), .free_count(free_count)
	);

	// 2 ns period.
	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	// Shadow of the pool: link words, head, empty flag, free count and rebuild mark.
	logic [fla_pkg::IDX_W-1:0] chain_link [fla_pkg::MAX_BLOCKS];
	logic [fla_pkg::IDX_W-1:0] chain_head;
	logic                      chain_empty;
	logic [fla_pkg::CNT_W-1:0] blocks_free;
	logic [fla_pkg::CNT_W-1:0] chain_mark;
	logic [fla_pkg::CFG_W-1:0] count_reg;

	// Blocks handed out and not yet returned; the generator frees from here.
	logic [fla_pkg::IDX_W-1:0] held_blocks [$];
	// One reply per accepted transaction, oldest first.
	pool_reply_t      replies_due [$];
	plan_row_t        plan [$];

	int unsigned mismatches = 0;
	int unsigned cycle_ct = 0;
	int unsigned burst_left = 0;

	task automatic flag_mismatch(input string what, input int unsigned got,
			input int unsigned want);
		$display("MISMATCH %s: got %0d, expected %0d at %0t", what, got, want, $time);
		mismatches++;
	endtask

	// Chain blocks 0 .. n-1 in ascending order, n being the clamped block count.
	function automatic void rechain_pool();
		int unsigned n;
		n = count_reg;
		if (n < 1) n = 1;
		if (n > fla_pkg::MAX_BLOCKS) n = fla_pkg::MAX_BLOCKS;
		for (int b = 0; b + 1 < n; b++) chain_link[b] = fla_pkg::IDX_W'(b + 1);
		chain_link[n - 1] = '0;
		chain_head  = '0;
		chain_empty = 1'b0;
		blocks_free = fla_pkg::CNT_W'(n);
		chain_mark  = fla_pkg::CNT_W'(n);
		held_blocks.delete();
	endfunction

	// Apply one command to the shadow pool and return the reply it must give.
	function automatic pool_reply_t next_pool_reply(input logic [fla_pkg::CMD_W-1:0] c,
			input logic [fla_pkg::IDX_W-1:0] idx);
		pool_reply_t r;
		r.status  = fla_pkg::STAT_OK;
		r.granted = '0;
		case (c)
		fla_pkg::CMD_ALLOC: begin
			if (chain_empty || blocks_free == 0) begin
				r.status = fla_pkg::STAT_EMPTY;
			end else begin
				r.granted = chain_head;
				held_blocks.push_back(chain_head);
				chain_head = chain_link[chain_head];
				blocks_free--;
				if (blocks_free == 0) chain_empty = 1'b1;
			end
		end
		fla_pkg::CMD_FREE: begin
			if (fla_pkg::CNT_W'(idx) >= chain_mark) begin
				r.status = fla_pkg::STAT_RANGE;
			end else begin
				// Double frees push again; the count stops at the mark.
				chain_link[idx] = chain_head;
				chain_head = idx;
				chain_empty = 1'b0;
				if (blocks_free < chain_mark) blocks_free++;
			end
		end
		fla_pkg::CMD_REBUILD: begin
			rechain_pool();
		end
		default: begin
		end
		endcase
		r.count = blocks_free;
		return r;
	endfunction

	function automatic void add_cfg(input logic [fla_pkg::CFG_W-1:0] v);
		plan_row_t row;
		row = '{is_cfg: 1'b1, cfg: v, cmd: CMD_NOP, idx: '0, typed: 1'b0, reply: '0};
		plan.push_back(row);
	endfunction

	function automatic void add_cmd(input logic [fla_pkg::CMD_W-1:0] c,
			input logic [fla_pkg::IDX_W-1:0] i, input bit typed,
			input logic [fla_pkg::STAT_W-1:0] st, input logic [fla_pkg::IDX_W-1:0] gr,
			input logic [fla_pkg::CNT_W-1:0] cnt);
		plan_row_t row;
		row = '{is_cfg: 1'b0, cfg: '0, cmd: c, idx: i, typed: typed,
			reply: '{status: st, granted: gr, count: cnt}};
		plan.push_back(row);
	endfunction

	// Drive one transaction and hold it until accepted; valid stays high on return.
	task automatic issue(input logic [fla_pkg::CMD_W-1:0] c,
			input logic [fla_pkg::IDX_W-1:0] i, input bit typed, input pool_reply_t want);
		pool_reply_t r;
		@(negedge clk);
		in_valid    <= 1'b1;
		command     <= c;
		block_index <= i;
		do @(posedge clk); while (in_stall);
		r = next_pool_reply(c, i);
		replies_due.push_back(typed ? want : r);
	endtask

	// Keep valid up through a burst; at its end drop valid for a random gap.
	task automatic pace_sender();
		int unsigned gap;
		if (burst_left > 0) begin
			burst_left--;
		end else begin
			gap = $urandom_range(1, 10);
			burst_left = $urandom_range(0, 24);
			@(negedge clk) in_valid <= 1'b0;
			repeat (gap - 1) @(negedge clk);
		end
	endtask

	// Drop valid, wait for every reply, then let the block settle.
	task automatic settle_pool();
		@(negedge clk) in_valid <= 1'b0;
		while (replies_due.size() != 0) @(posedge clk);
		repeat (8) @(posedge clk);
	endtask

	// Write block_count over APB (junk in the unused upper bits), then read it back.
	task automatic program_block_count(input logic [fla_pkg::CFG_W-1:0] v);
		@(negedge clk);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= {fla_pkg::REG_BLOCK_COUNT, 2'b00};
		pwdata  <= {(fla_pkg::APB_DW - fla_pkg::CFG_W)'($urandom), v};
		@(negedge clk) penable <= 1'b1;
		do @(posedge clk); while (!pready);
		count_reg = v;
		@(negedge clk);
		penable <= 1'b0;
		pwrite  <= 1'b0;
		@(negedge clk) penable <= 1'b1;
		do @(posedge clk); while (!pready);
		if (prdata !== fla_pkg::APB_DW'(v)) flag_mismatch("block_count readback", prdata, v);
		@(negedge clk);
		psel    <= 1'b0;
		penable <= 1'b0;
	endtask

	// Receiver: stretches of no stall, random stall, a fixed pattern, or a long hold.
	initial begin
		int unsigned mode, run;
		out_stall = 1'b0;
		forever begin
			mode = $urandom_range(0, 3);
			run  = $urandom_range(4, 40);
			for (int s = 0; s < run; s++) begin
				@(negedge clk);
				case (mode)
				0: out_stall <= 1'b0;
				1: out_stall <= 1'($urandom_range(0, 1));
				2: out_stall <= (s % 3 == 2);
				default: out_stall <= (s < 12);
				endcase
			end
		end
	end

	// Check each result transaction against the oldest awaited reply.
	always @(posedge clk) begin
		pool_reply_t want;
		if (arst_n && out_valid && !out_stall) begin
			if (replies_due.size() == 0) begin
				flag_mismatch("result with nothing awaited, status", status, 0);
			end else begin
				want = replies_due.pop_front();
				if (status !== want.status) flag_mismatch("status", status, want.status);
				if (granted_index !== want.granted)
					flag_mismatch("granted_index", granted_index, want.granted);
				if (free_count !== want.count)
					flag_mismatch("free_count", free_count, want.count);
			end
		end
	end

	// Watchdog: a hang or a lost result ends here.
	always @(posedge clk) begin
		cycle_ct <= cycle_ct + 1;
		if (cycle_ct >= CYCLE_LIMIT) begin
			$display("free_list_block_allocator regression: fail");
			$finish;
		end
	end

	initial begin
		int unsigned sizes [PHASES];
		int unsigned pick, bias, k;
		logic [fla_pkg::CMD_W-1:0] c;
		logic [fla_pkg::IDX_W-1:0] i;

		// Every input known from time zero; hold reset, then release it at a falling edge.
		arst_n      = 1'b0;
		psel        = 1'b0;
		penable     = 1'b0;
		pwrite      = 1'b0;
		paddr       = '0;
		pwdata      = '0;
		in_valid    = 1'b0;
		command     = fla_pkg::CMD_ALLOC;
		block_index = '0;
		count_reg   = fla_pkg::CFG_W'(fla_pkg::MAX_BLOCKS);
		rechain_pool();
		bias = 50;
		repeat (4) @(posedge clk);
		@(negedge clk) arst_n <= 1'b1;

		// Directed table. Out of reset: full pool of 256, head at block 0.
		add_cmd(fla_pkg::CMD_ALLOC, 8'h00, 1, fla_pkg::STAT_OK, 8'd0, 9'd255);
		add_cmd(fla_pkg::CMD_ALLOC, 8'hFF, 1, fla_pkg::STAT_OK, 8'd1, 9'd254);  // index ignored
		add_cmd(fla_pkg::CMD_FREE, 8'hFF, 1, fla_pkg::STAT_OK, 8'd0, 9'd255);   // far past frontier
		add_cmd(fla_pkg::CMD_FREE, 8'h00, 1, fla_pkg::STAT_OK, 8'd0, 9'd256);
		add_cmd(fla_pkg::CMD_FREE, 8'h00, 1, fla_pkg::STAT_OK, 8'd0, 9'd256);   // double free
		add_cmd(fla_pkg::CMD_ALLOC, 8'h00, 0, '0, '0, '0);              // follows the self-loop
		add_cmd(fla_pkg::CMD_ALLOC, 8'h00, 0, '0, '0, '0);
		add_cmd(CMD_NOP, 8'hAA, 0, '0, '0, '0);
		add_cmd(fla_pkg::CMD_REBUILD, 8'h55, 1, fla_pkg::STAT_OK, 8'd0, 9'd256);
		// New count waits for the next rebuild.
		add_cfg(9'd2);
		add_cmd(fla_pkg::CMD_FREE, 8'd200, 1, fla_pkg::STAT_OK, 8'd0, 9'd256);
		add_cmd(fla_pkg::CMD_REBUILD, 8'h00, 1, fla_pkg::STAT_OK, 8'd0, 9'd2);
		add_cmd(fla_pkg::CMD_ALLOC, 8'h00, 1, fla_pkg::STAT_OK, 8'd0, 9'd1);
		add_cmd(fla_pkg::CMD_ALLOC, 8'h00, 1, fla_pkg::STAT_OK, 8'd1, 9'd0);
		add_cmd(fla_pkg::CMD_ALLOC, 8'h00, 1, fla_pkg::STAT_EMPTY, 8'd0, 9'd0);
		add_cmd(fla_pkg::CMD_FREE, 8'd2, 1, fla_pkg::STAT_RANGE, 8'd0, 9'd0);
		add_cmd(fla_pkg::CMD_FREE, 8'hFF, 1, fla_pkg::STAT_RANGE, 8'd0, 9'd0);
		add_cmd(fla_pkg::CMD_FREE, 8'd1, 1, fla_pkg::STAT_OK, 8'd0, 9'd1);
		add_cmd(fla_pkg::CMD_ALLOC, 8'h00, 1, fla_pkg::STAT_OK, 8'd1, 9'd0);
		// A count of zero acts as one.
		add_cfg(9'd0);
		add_cmd(fla_pkg::CMD_REBUILD, 8'h00, 1, fla_pkg::STAT_OK, 8'd0, 9'd1);
		add_cmd(fla_pkg::CMD_FREE, 8'd1, 1, fla_pkg::STAT_RANGE, 8'd0, 9'd1);
		add_cmd(fla_pkg::CMD_ALLOC, 8'h00, 1, fla_pkg::STAT_OK, 8'd0, 9'd0);
		add_cmd(fla_pkg::CMD_ALLOC, 8'h00, 1, fla_pkg::STAT_EMPTY, 8'd0, 9'd0);
		add_cmd(CMD_NOP, 8'h00, 1, fla_pkg::STAT_OK, 8'd0, 9'd0);
		// Above the maximum acts as the maximum.
		add_cfg(9'd511);
		add_cmd(fla_pkg::CMD_REBUILD, 8'h00, 1, fla_pkg::STAT_OK, 8'd0, 9'd256);
		add_cmd(fla_pkg::CMD_FREE, 8'hFF, 1, fla_pkg::STAT_OK, 8'd0, 9'd256);

		foreach (plan[r]) begin
			if (plan[r].is_cfg) begin
				settle_pool();
				program_block_count(plan[r].cfg);
			end else begin
				issue(plan[r].cmd, plan[r].idx, plan[r].typed, plan[r].reply);
				pace_sender();
			end
		end

		// Random phases: mostly small pools, extremes in between.
		sizes = '{256, 1, 6, 0, 24, 511, 3, 0};
		sizes[PHASES - 1] = $urandom_range(2, 48);
		for (int ph = 0; ph < PHASES; ph++) begin
			settle_pool();
			program_block_count(fla_pkg::CFG_W'(sizes[ph]));
			issue(fla_pkg::CMD_REBUILD, fla_pkg::IDX_W'($urandom), 1'b0, '0);
			pace_sender();
			for (int n = 1; n < ITEMS_PER_PHASE; n++) begin
				// Re-tilt allocate against free so the pool drains and refills.
				if (n % 25 == 1) bias = $urandom_range(15, 85);
				pick = $urandom_range(0, 99);
				i = fla_pkg::IDX_W'($urandom);
				if (pick < 2) begin
					c = CMD_NOP;
				end else if (pick < 4) begin
					c = fla_pkg::CMD_REBUILD;
				end else if (pick < 12) begin
					// Stray free: out of range, double free, or past the frontier.
					c = fla_pkg::CMD_FREE;
					if ($urandom_range(0, 1))
						i = fla_pkg::IDX_W'($urandom_range(0, chain_mark));
				end else if (held_blocks.size() == 0 || $urandom_range(0, 99) < bias) begin
					c = fla_pkg::CMD_ALLOC;
				end else begin
					k = $urandom_range(0, held_blocks.size() - 1);
					c = fla_pkg::CMD_FREE;
					i = held_blocks[k];
					held_blocks.delete(k);
				end
				issue(c, i, 1'b0, '0);
				pace_sender();
			end
		end

		settle_pool();
		if (mismatches == 0) begin
			$display("free_list_block_allocator regression: pass");
		end else begin
			$display("free_list_block_allocator regression: fail");
		end
		$finish;
	end

endmodule

// ===== free_list_block_allocator.f =====
design/fla_pkg.sv
design/fla_ram.sv
design/fla_ctrl.sv
design/fla_dp.sv
design/free_list_block_allocator.sv
tb/sv/free_list_block_allocator_tb.sv
